### rtl/core/slwa_pkg.sv
package slwa_pkg;

   localparam int ID_W              = 12;
   localparam int DATA_W            = 32;
   localparam int SUM_W             = 48;
   localparam int DIV_W             = SUM_W + 1;
   localparam int TALLY_W           = 13;
   localparam int DEF_MAX_INSTANCES = 4096;
   localparam int DEF_FRAC_BITS     = 16;

   localparam logic [TALLY_W-1:0] TALLY_MAX    = 13'd8191;
   localparam logic [DATA_W-1:0]  LAMBDA_RESET = 32'h0001_0000;
   localparam logic [DATA_W-1:0]  WEIGHT_MAX   = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0]  WEIGHT_MIN   = 32'h8000_0000;

   localparam logic CMD_FLAG = 1'b0;
   localparam logic CMD_GRAD = 1'b1;

   typedef struct packed {
      logic flag_wr;
      logic flag_rd;
      logic accum;
      logic div_start;
      logic div_right;
      logic take_left;
      logic take_right;
      logic load_out;
   } slwa_cmd_type;

   typedef struct packed {
      logic div_done;
   } slwa_status_type;

endpackage

### rtl/core/slwa_channels.sv
interface slwa_req_if;
   import slwa_pkg::*;

   logic              valid;
   logic              ready;
   logic              cmd;
   logic [ID_W-1:0]   instance_id;
   logic              flag_value;
   logic [DATA_W-1:0] gradient;
   logic [DATA_W-1:0] hessian;
   logic              last_of_node;

   modport source (
      output valid, cmd, instance_id, flag_value, gradient, hessian, last_of_node,
      input  ready
   );
   modport sink (
      input  valid, cmd, instance_id, flag_value, gradient, hessian, last_of_node,
      output ready
   );
endinterface

interface slwa_rsp_if;
   import slwa_pkg::*;

   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  left_weight;
   logic [DATA_W-1:0]  right_weight;
   logic [TALLY_W-1:0] left_count;
   logic [TALLY_W-1:0] right_count;
   logic               zero_divisor;

   modport source (
      output valid, left_weight, right_weight, left_count, right_count, zero_divisor,
      input  ready
   );
   modport sink (
      input  valid, left_weight, right_weight, left_count, right_count, zero_divisor,
      output ready
   );
endinterface

### rtl/core/split_leaf_weight_accumulator_core.sv
// Flag-load request: accepted and written to the flag store; the next request is taken in the next cycle.
// Gradient request: flag store read, then accumulate.
// Last request of a node: after the accumulate, the shared one-bit-per-cycle divider runs once per side,
// left then right, and the result register loads once the output register is free or being emptied.
// Reset is synchronous: it clears control, sums, counts and sets lambda to 1.0; the
// flag store is not cleared and must be written before it is read.
module split_leaf_weight_accumulator_core #(
   parameter int MAX_INSTANCES = slwa_pkg::DEF_MAX_INSTANCES,
   parameter int FRAC_BITS     = slwa_pkg::DEF_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [slwa_pkg::DATA_W-1:0]  csr_wr_data,
   slwa_req_if.sink                     req_ch,
   slwa_rsp_if.source                   rsp_ch
);
   import slwa_pkg::*;

   slwa_cmd_type    cmd;
   slwa_status_type status;

   slwa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_last  (req_ch.last_of_node),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   slwa_datapath #(
      .MAX_INSTANCES (MAX_INSTANCES),
      .FRAC_BITS     (FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_instance_id  (req_ch.instance_id),
      .req_flag_value   (req_ch.flag_value),
      .req_gradient     (req_ch.gradient),
      .req_hessian      (req_ch.hessian),
      .rsp_left_weight  (rsp_ch.left_weight),
      .rsp_right_weight (rsp_ch.right_weight),
      .rsp_left_count   (rsp_ch.left_count),
      .rsp_right_count  (rsp_ch.right_count),
      .rsp_zero_divisor (rsp_ch.zero_divisor)
   );

endmodule

### rtl/core/slwa_divider.sv
module slwa_divider #(
   parameter int FRAC_BITS = slwa_pkg::DEF_FRAC_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [slwa_pkg::SUM_W-1:0]   numer,
   input  logic [slwa_pkg::DIV_W-1:0]   denom,
   output logic                         done,
   output logic                         zero,
   output logic [slwa_pkg::DATA_W-1:0]  weight
);
   import slwa_pkg::*;

   localparam int NUM_W = SUM_W + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [SUM_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] nd_ff, nd_in;
   logic [DATA_W:0]  q_ff, q_in;
   logic             big_ff, big_in;
   logic             neg_ff, neg_in;
   logic             zero_ff, zero_in;

   logic [SUM_W-1:0] ng_abs;
   logic [DIV_W-1:0] nd_abs;
   logic [SUM_W:0]   rem_sh;
   logic             ge;

   always_comb begin
      ng_abs = numer[SUM_W-1] ? (SUM_W'(0) - numer) : numer;
      nd_abs = denom[DIV_W-1] ? (DIV_W'(0) - denom) : denom;
      rem_sh = {rem_ff, num_ff[NUM_W-1]};
      ge     = rem_sh >= {1'b0, nd_ff};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      nd_in   = nd_ff;
      q_in    = q_ff;
      big_in  = big_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;

      if (start) begin
         zero_in = (denom == DIV_W'(0));
         neg_in  = (numer[SUM_W-1] == denom[DIV_W-1]);
         num_in  = NUM_W'(ng_abs) << FRAC_BITS;
         nd_in   = nd_abs[SUM_W-1:0];
         rem_in  = '0;
         q_in    = '0;
         big_in  = 1'b0;
         cnt_in  = CNT_W'(NUM_W - 1);
         busy_in = (denom != DIV_W'(0));
         done_in = (denom == DIV_W'(0));
      end else if (busy_ff) begin
         // Restoring division, one quotient bit per cycle.  Any quotient bit
         // above bit 31 only matters as a saturation marker.
         rem_in = ge ? SUM_W'(rem_sh - {1'b0, nd_ff}) : rem_sh[SUM_W-1:0];
         num_in = num_ff << 1;
         q_in   = {q_ff[DATA_W-1:0], ge};
         big_in = big_ff | q_ff[DATA_W];
         if (cnt_ff == CNT_W'(0)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      nd_ff   <= nd_in;
      q_ff    <= q_in;
      big_ff  <= big_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      if (zero_ff) begin
         weight = '0;
      end else if (neg_ff) begin
         if (big_ff || q_ff > {1'b0, WEIGHT_MIN}) begin
            weight = WEIGHT_MIN;
         end else begin
            weight = DATA_W'(0) - q_ff[DATA_W-1:0];
         end
      end else begin
         if (big_ff || q_ff > {1'b0, WEIGHT_MAX}) begin
            weight = WEIGHT_MAX;
         end else begin
            weight = q_ff[DATA_W-1:0];
         end
      end
   end

   assign done = done_ff;
   assign zero = zero_ff;

endmodule

### rtl/core/slwa_datapath.sv
module slwa_datapath #(
   parameter int MAX_INSTANCES = slwa_pkg::DEF_MAX_INSTANCES,
   parameter int FRAC_BITS     = slwa_pkg::DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  slwa_pkg::slwa_cmd_type        cmd,
   output slwa_pkg::slwa_status_type     status,
   input  logic                          csr_wr_en,
   input  logic [slwa_pkg::DATA_W-1:0]   csr_wr_data,
   input  logic [slwa_pkg::ID_W-1:0]     req_instance_id,
   input  logic                          req_flag_value,
   input  logic [slwa_pkg::DATA_W-1:0]   req_gradient,
   input  logic [slwa_pkg::DATA_W-1:0]   req_hessian,
   output logic [slwa_pkg::DATA_W-1:0]   rsp_left_weight,
   output logic [slwa_pkg::DATA_W-1:0]   rsp_right_weight,
   output logic [slwa_pkg::TALLY_W-1:0]  rsp_left_count,
   output logic [slwa_pkg::TALLY_W-1:0]  rsp_right_count,
   output logic                          rsp_zero_divisor
);
   import slwa_pkg::*;

   localparam int AW = (MAX_INSTANCES > 1) ? $clog2(MAX_INSTANCES) : 1;
   localparam int CW = ((AW > ID_W) ? AW : ID_W) + 1;

   logic flag_mem [MAX_INSTANCES];

   logic [CW-1:0]      id_ext;
   logic               id_ok;
   logic [AW-1:0]      idx;

   logic               flag_q_ff;
   logic               id_ok_ff;
   logic [DATA_W-1:0]  grad_ff;
   logic [DATA_W-1:0]  hess_ff;
   logic [DATA_W-1:0]  lambda_ff;

   logic [SUM_W-1:0]   lg_sum_ff, lg_sum_in;
   logic [SUM_W-1:0]   lh_sum_ff, lh_sum_in;
   logic [SUM_W-1:0]   rg_sum_ff, rg_sum_in;
   logic [SUM_W-1:0]   rh_sum_ff, rh_sum_in;
   logic [TALLY_W-1:0] l_tally_ff, l_tally_in;
   logic [TALLY_W-1:0] r_tally_ff, r_tally_in;

   logic [DATA_W-1:0]  left_w_ff, right_w_ff;
   logic               left_z_ff, right_z_ff;

   logic [SUM_W-1:0]   grad_ext, hess_ext;
   logic               goes_left;
   logic [SUM_W-1:0]   div_g;
   logic [SUM_W-1:0]   div_h;
   logic [DIV_W-1:0]   div_d;
   logic               div_done;
   logic               div_zero;
   logic [DATA_W-1:0]  div_weight;

   always_comb begin
      id_ext = CW'(req_instance_id);
      id_ok  = id_ext < CW'(MAX_INSTANCES);
      idx    = id_ext[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.flag_wr && id_ok) begin
         flag_mem[idx] <= req_flag_value;
      end
      if (cmd.flag_rd) begin
         flag_q_ff <= flag_mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.flag_rd) begin
         id_ok_ff <= id_ok;
         grad_ff  <= req_gradient;
         hess_ff  <= req_hessian;
      end
   end

   always_comb begin
      grad_ext  = {{(SUM_W-DATA_W){grad_ff[DATA_W-1]}}, grad_ff};
      hess_ext  = {{(SUM_W-DATA_W){hess_ff[DATA_W-1]}}, hess_ff};
      goes_left = id_ok_ff & flag_q_ff;

      lg_sum_in  = lg_sum_ff;
      lh_sum_in  = lh_sum_ff;
      rg_sum_in  = rg_sum_ff;
      rh_sum_in  = rh_sum_ff;
      l_tally_in = l_tally_ff;
      r_tally_in = r_tally_ff;

      if (cmd.load_out) begin
         lg_sum_in  = '0;
         lh_sum_in  = '0;
         rg_sum_in  = '0;
         rh_sum_in  = '0;
         l_tally_in = '0;
         r_tally_in = '0;
      end else if (cmd.accum) begin
         if (goes_left) begin
            lg_sum_in = lg_sum_ff + grad_ext;
            lh_sum_in = lh_sum_ff + hess_ext;
            if (l_tally_ff != TALLY_MAX) begin
               l_tally_in = l_tally_ff + TALLY_W'(1);
            end
         end else begin
            rg_sum_in = rg_sum_ff + grad_ext;
            rh_sum_in = rh_sum_ff + hess_ext;
            if (r_tally_ff != TALLY_MAX) begin
               r_tally_in = r_tally_ff + TALLY_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lg_sum_ff  <= '0;
         lh_sum_ff  <= '0;
         rg_sum_ff  <= '0;
         rh_sum_ff  <= '0;
         l_tally_ff <= '0;
         r_tally_ff <= '0;
         lambda_ff  <= LAMBDA_RESET;
      end else begin
         lg_sum_ff  <= lg_sum_in;
         lh_sum_ff  <= lh_sum_in;
         rg_sum_ff  <= rg_sum_in;
         rh_sum_ff  <= rh_sum_in;
         l_tally_ff <= l_tally_in;
         r_tally_ff <= r_tally_in;
         if (csr_wr_en) begin
            lambda_ff <= csr_wr_data;
         end
      end
   end

   // The divisor is the hessian sum, sign extended by one bit, plus lambda.
   always_comb begin
      div_g = cmd.div_right ? rg_sum_ff : lg_sum_ff;
      div_h = cmd.div_right ? rh_sum_ff : lh_sum_ff;
      div_d = {div_h[SUM_W-1], div_h} + {{(DIV_W-DATA_W){1'b0}}, lambda_ff};
   end

   slwa_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .numer  (div_g),
      .denom  (div_d),
      .done   (div_done),
      .zero   (div_zero),
      .weight (div_weight)
   );

   assign status.div_done = div_done;

   always_ff @(posedge clock) begin
      if (cmd.take_left) begin
         left_w_ff <= div_weight;
         left_z_ff <= div_zero;
      end
      if (cmd.take_right) begin
         right_w_ff <= div_weight;
         right_z_ff <= div_zero;
      end
      if (cmd.load_out) begin
         rsp_left_weight  <= left_w_ff;
         rsp_right_weight <= right_w_ff;
         rsp_left_count   <= l_tally_ff;
         rsp_right_count  <= r_tally_ff;
         rsp_zero_divisor <= left_z_ff | right_z_ff;
      end
   end

endmodule

### rtl/core/slwa_ctrl.sv
module slwa_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_cmd,
   input  logic                       req_last,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output slwa_pkg::slwa_cmd_type     cmd,
   input  slwa_pkg::slwa_status_type  status
);
   import slwa_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ACCUM,
      S_DIV_L_GO,
      S_DIV_L,
      S_DIV_R,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == CMD_FLAG) begin
                  cmd.flag_wr = 1'b1;
               end else begin
                  cmd.flag_rd = 1'b1;
                  last_in     = req_last;
                  state_in    = S_ACCUM;
               end
            end
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = last_ff ? S_DIV_L_GO : S_IDLE;
         end
         S_DIV_L_GO: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV_L;
         end
         S_DIV_L: begin
            if (status.div_done) begin
               cmd.take_left = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_right = 1'b1;
               state_in      = S_DIV_R;
            end
         end
         S_DIV_R: begin
            if (status.div_done) begin
               cmd.take_right = 1'b1;
               state_in       = S_EMIT;
            end
         end
         S_EMIT: begin
            // Wait until the output register is free or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
